// ===== src/rss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types, widths and codes for the range session sequencer.
// ----------------------------------------------------------------------------
package rss_pkg;

    // field widths
    localparam int KIND_W     = 2;
    localparam int TIME_W     = 32;
    localparam int DIST_BITS  = 12;
    localparam int FRAC_BITS  = 8;
    localparam int STATUS_W   = 8;
    localparam int VALUE_W    = DIST_BITS + FRAC_BITS;
    localparam int PHASE_W    = 3;
    localparam int EVENT_W    = 4;
    localparam int MS_W       = 20;
    localparam int RANGE_W    = 12;
    localparam int WEIGHT_W   = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = MS_W;
    localparam int COUNT_W    = 2;

    // average weight is out of 256
    localparam int WEIGHT_SHIFT = 8;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(256);

    // register reset values
    localparam logic [MS_W-1:0]     ARMING_MS_RST   = MS_W'(2000);
    localparam logic [MS_W-1:0]     COUNTDOWN_MS_RST = MS_W'(5000);
    localparam logic [MS_W-1:0]     SESSION_MS_RST  = MS_W'(60000);
    localparam logic [MS_W-1:0]     END_HOLD_MS_RST = MS_W'(2000);
    localparam logic [MS_W-1:0]     END_TMO_MS_RST  = MS_W'(5000);
    localparam logic [RANGE_W-1:0]  STABLE_MM_RST   = RANGE_W'(25);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST      = WEIGHT_W'(77);

    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_START  = 2'd1,
        KIND_STOP   = 2'd2
    } kind_e_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE      = 3'd0,
        PH_ARMING    = 3'd1,
        PH_COUNTDOWN = 3'd2,
        PH_RECORDING = 3'd3,
        PH_END_HOLD  = 3'd4
    } phase_e_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_SAMPLE     = 4'd0,
        EV_START      = 4'd1,
        EV_ARMING     = 4'd2,
        EV_STOP       = 4'd3,
        EV_STOP_IDLE  = 4'd4,
        EV_ERROR      = 4'd5,
        EV_BASELINE   = 4'd6,
        EV_COUNTDOWN  = 4'd7,
        EV_HOLD_STILL = 4'd8,
        EV_REC        = 4'd9,
        EV_END_HOLD   = 4'd10,
        EV_CLEAN      = 4'd11,
        EV_TIMEOUT    = 4'd12
    } event_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ARMING_MS       = 3'd0,
        REG_COUNTDOWN_MS    = 3'd1,
        REG_SESSION_MS      = 3'd2,
        REG_END_HOLD_MS     = 3'd3,
        REG_END_HOLD_TMO_MS = 3'd4,
        REG_STABLE_RANGE_MM = 3'd5,
        REG_SMOOTH_WEIGHT   = 3'd6
    } cfg_reg_e_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [TIME_W-1:0]   now_ms;
        logic [DIST_BITS-1:0] distance_mm;
        logic                distance_valid;
        logic [STATUS_W-1:0] sensor_status;
    } item_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [VALUE_W-1:0] value;
        logic [PHASE_W-1:0] phase;
        logic [TIME_W-1:0]  time_ms;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        res_t               res0;
        res_t               res1;
    } step_out_t;

    typedef struct packed {
        logic [MS_W-1:0]     arm_len;
        logic [MS_W-1:0]     cd_len;
        logic [MS_W-1:0]     rec_max;
        logic [MS_W-1:0]     hold_len;
        logic [MS_W-1:0]     hold_tmo;
        logic [RANGE_W-1:0]  still_mm;
        logic [WEIGHT_W-1:0] smoothing_weight;
    } cfg_t;

endpackage

// ===== src/rss_item_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_item_if
// Valid/ready channel carrying commands and distance samples.
// ----------------------------------------------------------------------------
interface rss_item_if;
    import rss_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [TIME_W-1:0]    now_ms;
    logic [DIST_BITS-1:0] distance_mm;
    logic                 distance_valid;
    logic [STATUS_W-1:0]  sensor_status;

    modport source (
        output valid, kind, now_ms, distance_mm, distance_valid, sensor_status,
        input  ready
    );

    modport sink (
        input  valid, kind, now_ms, distance_mm, distance_valid, sensor_status,
        output ready
    );
endinterface

// ===== src/rss_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_result_if
// Valid/ready channel carrying sequencer events.
// ----------------------------------------------------------------------------
interface rss_result_if;
    import rss_pkg::*;

    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [VALUE_W-1:0] value;
    logic [PHASE_W-1:0] phase;
    logic [TIME_W-1:0]  time_ms;
    logic               last;

    modport source (
        output valid, event_res, value, phase, time_ms, last,
        input  ready
    );

    modport sink (
        input  valid, event_res, value, phase, time_ms, last,
        output ready
    );
endinterface

// ===== src/rss_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_seq
// Session state, smoothing datapath and phase sequencing for one item.
// ----------------------------------------------------------------------------
module rss_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  rss_pkg::item_t    item,
    input  rss_pkg::cfg_t     cfg,
    output rss_pkg::step_out_t step
);
    import rss_pkg::*;

    localparam int DIFF_W = VALUE_W + 1;
    localparam int PROD_W = DIFF_W + WEIGHT_W + 1;
    localparam int ACC_W  = PROD_W - WEIGHT_SHIFT;

    // session state
    phase_e_t            phase_reg, phase_next;
    logic [TIME_W-1:0]   start_reg, start_next;
    logic [VALUE_W-1:0]  avg_reg, avg_next;
    logic                started_reg, started_next;
    logic [VALUE_W-1:0]  low_reg, low_next;
    logic [VALUE_W-1:0]  high_reg, high_next;
    logic                pend_reg, pend_next;

    // datapath
    logic [VALUE_W-1:0]         raw;
    logic [WEIGHT_W-1:0]        w_sat;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    delta;
    logic signed [ACC_W-1:0]    acc;
    logic [VALUE_W-1:0]         avg_new;
    logic [VALUE_W-1:0]         lo_base, hi_base, lo_new, hi_new;
    logic [VALUE_W-1:0]         span;
    logic [VALUE_W-1:0]         limit;
    logic                       span_ok;
    logic [TIME_W-1:0]          elapsed;
    logic                       arm_due, cd_due, sess_due, hold_due, tmo_due;
    logic                       good_sample;

    function automatic res_t mk_res(input event_e_t ev, input logic [VALUE_W-1:0] val,
                                    input phase_e_t ph, input logic [TIME_W-1:0] t);
        res_t r;
        r.event_res = ev;
        r.value     = val;
        r.phase     = ph;
        r.time_ms   = t;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic logic [TIME_W-1:0] ms_ext(input logic [MS_W-1:0] ms);
        return {{(TIME_W - MS_W){1'b0}}, ms};
    endfunction

    // exponential average, window and elapsed time
    always_comb
    begin
        raw     = {item.distance_mm, {FRAC_BITS{1'b0}}};
        w_sat   = (cfg.smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.smoothing_weight;
        diff    = $signed({1'b0, raw}) - $signed({1'b0, avg_reg});
        prod    = diff * $signed({1'b0, w_sat});
        delta   = $signed(prod[PROD_W-1:WEIGHT_SHIFT]);
        acc     = $signed({{(ACC_W - VALUE_W){1'b0}}, avg_reg}) + delta;
        avg_new = started_reg ? acc[VALUE_W-1:0] : raw;
        lo_base = started_reg ? low_reg : raw;
        hi_base = started_reg ? high_reg : raw;
        lo_new  = (avg_new < lo_base) ? avg_new : lo_base;
        hi_new  = (avg_new > hi_base) ? avg_new : hi_base;
        span    = (hi_new >= lo_new) ? (hi_new - lo_new) : '0;
        limit   = {cfg.still_mm, {FRAC_BITS{1'b0}}};
        span_ok = (span <= limit);
        elapsed = item.now_ms - start_reg;
        arm_due  = (elapsed >= ms_ext(cfg.arm_len));
        cd_due   = (elapsed >= ms_ext(cfg.cd_len));
        sess_due = (elapsed >= ms_ext(cfg.rec_max));
        hold_due = (elapsed >= ms_ext(cfg.hold_len));
        tmo_due  = (elapsed >= ms_ext(cfg.hold_tmo));
        good_sample = (phase_reg != PH_IDLE) && item.distance_valid;
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        start_next   = start_reg;
        avg_next     = avg_reg;
        started_next = started_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        pend_next    = pend_reg;
        if (fire)
        begin
            unique case (kind_e_t'(item.kind))
                KIND_START:
                begin
                    phase_next = PH_ARMING;
                    start_next = item.now_ms;
                    pend_next  = 1'b0;
                end
                KIND_STOP:
                begin
                    if (phase_reg == PH_RECORDING)
                        pend_next = 1'b1;
                    else
                        phase_next = PH_IDLE;
                end
                KIND_SAMPLE:
                begin
                    if (good_sample)
                    begin
                        avg_next     = avg_new;
                        started_next = 1'b1;
                        low_next     = lo_new;
                        high_next    = hi_new;
                        unique case (phase_reg)
                            PH_ARMING:
                            begin
                                if (arm_due)
                                begin
                                    start_next = item.now_ms;
                                    low_next   = avg_new;
                                    high_next  = avg_new;
                                    if (span_ok)
                                        phase_next = PH_COUNTDOWN;
                                end
                            end
                            PH_COUNTDOWN:
                            begin
                                if (cd_due)
                                begin
                                    phase_next = PH_RECORDING;
                                    start_next = item.now_ms;
                                end
                            end
                            PH_RECORDING:
                            begin
                                if (pend_reg || sess_due)
                                begin
                                    phase_next = PH_END_HOLD;
                                    start_next = item.now_ms;
                                    pend_next  = 1'b0;
                                    low_next   = avg_new;
                                    high_next  = avg_new;
                                end
                            end
                            PH_END_HOLD:
                            begin
                                if (hold_due && (span_ok || tmo_due))
                                begin
                                    phase_next   = PH_IDLE;
                                    started_next = 1'b0;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // events for the item
    always_comb
    begin
        step.count = '0;
        step.res0  = mk_res(EV_SAMPLE, '0, PH_IDLE, item.now_ms);
        step.res1  = mk_res(EV_SAMPLE, '0, PH_IDLE, item.now_ms);
        unique case (kind_e_t'(item.kind))
            KIND_START:
            begin
                step.count = 2'd2;
                step.res0  = mk_res(EV_START, '0, PH_ARMING, item.now_ms);
                step.res1  = mk_res(EV_ARMING, '0, PH_ARMING, item.now_ms);
            end
            KIND_STOP:
            begin
                step.count = 2'd1;
                if (phase_reg == PH_RECORDING)
                    step.res0 = mk_res(EV_STOP, '0, PH_RECORDING, item.now_ms);
                else
                    step.res0 = mk_res(EV_STOP_IDLE, '0, PH_IDLE, item.now_ms);
            end
            KIND_SAMPLE:
            begin
                if (phase_reg != PH_IDLE && !item.distance_valid)
                begin
                    step.count = 2'd1;
                    step.res0  = mk_res(EV_ERROR,
                                        {{(VALUE_W - STATUS_W){1'b0}}, item.sensor_status},
                                        phase_reg, item.now_ms);
                end
                else if (good_sample)
                begin
                    unique case (phase_reg)
                        PH_ARMING:
                        begin
                            if (arm_due && span_ok)
                            begin
                                step.count = 2'd2;
                                step.res0  = mk_res(EV_BASELINE, avg_new, PH_ARMING,
                                                    item.now_ms);
                                step.res1  = mk_res(EV_COUNTDOWN, '0, PH_COUNTDOWN,
                                                    item.now_ms);
                            end
                            else if (arm_due)
                            begin
                                step.count = 2'd1;
                                step.res0  = mk_res(EV_HOLD_STILL, span, PH_ARMING,
                                                    item.now_ms);
                            end
                        end
                        PH_COUNTDOWN:
                        begin
                            if (cd_due)
                            begin
                                step.count = 2'd1;
                                step.res0  = mk_res(EV_REC, '0, PH_RECORDING, item.now_ms);
                            end
                        end
                        PH_RECORDING:
                        begin
                            step.count = 2'd1;
                            step.res0  = mk_res(EV_SAMPLE, raw, PH_RECORDING, item.now_ms);
                            if (pend_reg || sess_due)
                            begin
                                step.count = 2'd2;
                                step.res1  = mk_res(EV_END_HOLD, '0, PH_END_HOLD,
                                                    item.now_ms);
                            end
                        end
                        PH_END_HOLD:
                        begin
                            if (hold_due && span_ok)
                            begin
                                step.count = 2'd1;
                                step.res0  = mk_res(EV_CLEAN, span, PH_END_HOLD, item.now_ms);
                            end
                            else if (hold_due && tmo_due)
                            begin
                                step.count = 2'd1;
                                step.res0  = mk_res(EV_TIMEOUT, span, PH_END_HOLD,
                                                    item.now_ms);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
        step.res0.last = (step.count == 2'd1);
        step.res1.last = 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            start_reg   <= '0;
            avg_reg     <= '0;
            started_reg <= 1'b0;
            low_reg     <= '1;
            high_reg    <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            start_reg   <= start_next;
            avg_reg     <= avg_next;
            started_reg <= started_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            pend_reg    <= pend_next;
        end
    end

    // a start always lands in arming with no stop pending
    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.kind == KIND_START |=> phase_reg == PH_ARMING && !pend_reg)
        else $error("start did not enter arming");

    // a pending stop only exists while recording
    a_pend_rec: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> phase_reg == PH_RECORDING)
        else $error("stop pending outside recording");

    // with two events only the second is marked last
    a_two_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && step.count == 2'd2 |-> step.res1.last && !step.res0.last)
        else $error("last flag misplaced");

endmodule

// ===== src/rss_res_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_res_buf
// Two-slot event buffer that takes all events of one item at once and
// hands them out one transaction per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module rss_res_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  rss_pkg::step_out_t  wr_data,
    output logic                room,
    rss_result_if.source        events
);
    import rss_pkg::*;

    res_t               slot0_reg, slot0_next;
    res_t               slot1_reg, slot1_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               pop;

    // output side
    assign pop              = events.valid && events.ready;
    assign events.valid     = (cnt_reg != '0);
    assign events.event_res = slot0_reg.event_res;
    assign events.value     = slot0_reg.value;
    assign events.phase     = slot0_reg.phase;
    assign events.time_ms   = slot0_reg.time_ms;
    assign events.last      = slot0_reg.last;

    // space for a full item once the current head leaves
    assign room = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);

    // fill or shift
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (wr)
        begin
            slot0_next = wr_data.res0;
            slot1_next = wr_data.res1;
            cnt_next   = wr_data.count;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // a lone held event is always the final one of its item
    a_lone_last: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd1 |-> slot0_reg.last)
        else $error("single held event not marked last");

    // second event moves to the head after the first leaves
    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !wr && cnt_reg == 2'd2 |=> slot0_reg == $past(slot1_reg))
        else $error("second event lost on shift");

    // writer never overruns the buffer
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop))
        else $error("event buffer overrun");

endmodule

// ===== src/range_session_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_session_sequencer_core
// Ranging session sequencer: smooths distance samples, tracks the window
// span and steps through arming, countdown, recording and end hold.
// ----------------------------------------------------------------------------
// path: an item taken is registered in item_reg, its events in the output
//   buffer, which must have room for the whole item before it is written
// throughput: one item per cycle with at most one event and no receiver stall;
//   a two-event item holds the next until its second event leaves the port
// reset: phase idle, average and window cleared, registers to their defaults
// ----------------------------------------------------------------------------
module range_session_sequencer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    rss_item_if.sink                        items,
    rss_result_if.source                    events,
    input  logic                            cfg_wr_en,
    input  logic [rss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rss_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rss_pkg::*;

    item_t     item_reg;
    logic      vld_reg;
    cfg_t      cfg_reg;
    logic      room;
    logic      fire;
    logic      accept;
    step_out_t step;

    // input register handshake
    assign fire        = vld_reg && room;
    assign items.ready = !vld_reg || fire;
    assign accept      = items.valid && items.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (accept)
            vld_reg <= 1'b1;
        else if (fire)
            vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind           <= items.kind;
            item_reg.now_ms         <= items.now_ms;
            item_reg.distance_mm    <= items.distance_mm;
            item_reg.distance_valid <= items.distance_valid;
            item_reg.sensor_status  <= items.sensor_status;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arm_len          <= ARMING_MS_RST;
            cfg_reg.cd_len           <= COUNTDOWN_MS_RST;
            cfg_reg.rec_max          <= SESSION_MS_RST;
            cfg_reg.hold_len         <= END_HOLD_MS_RST;
            cfg_reg.hold_tmo         <= END_TMO_MS_RST;
            cfg_reg.still_mm         <= STABLE_MM_RST;
            cfg_reg.smoothing_weight <= WEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_e_t'(cfg_index))
                REG_ARMING_MS:       cfg_reg.arm_len          <= cfg_data[MS_W-1:0];
                REG_COUNTDOWN_MS:    cfg_reg.cd_len           <= cfg_data[MS_W-1:0];
                REG_SESSION_MS:      cfg_reg.rec_max          <= cfg_data[MS_W-1:0];
                REG_END_HOLD_MS:     cfg_reg.hold_len         <= cfg_data[MS_W-1:0];
                REG_END_HOLD_TMO_MS: cfg_reg.hold_tmo         <= cfg_data[MS_W-1:0];
                REG_STABLE_RANGE_MM: cfg_reg.still_mm         <= cfg_data[RANGE_W-1:0];
                REG_SMOOTH_WEIGHT:   cfg_reg.smoothing_weight <= cfg_data[WEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencing and smoothing
    rss_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .step  (step)
    );

    // event output buffer
    rss_res_buf u_res_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (fire),
        .wr_data (step),
        .room    (room),
        .events  (events)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for range_session_sequencer_core. A driver sends command
// and distance transactions from a queue, a monitor predicts the sequencer
// events and checks every returned event field by field, under several
// register settings and several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    import rss_pkg::*;

    // unused kind code, ignored by the block
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 50;

    typedef struct {
        item_t it;
        bit    drain_first;
    } pend_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic drv_valid = 1'b0;
    item_t drv_item = '0;
    logic rx_ready = 1'b0;
    bit item_fired = 1'b0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    pend_t pend_q[$];
    res_t exp_events[$];

    int unsigned err_count = 0;
    int unsigned n_items = 0;
    int unsigned n_events = 0;
    int unsigned n_settings = 0;
    int unsigned queued_items = 0;
    int unsigned ev_count[16];

    // mirror of the sequencer state and registers
    cfg_t regs;
    phase_e_t ph;
    logic [TIME_W-1:0] ph_t0;
    logic [VALUE_W-1:0] avg;
    bit avg_on;
    logic [VALUE_W-1:0] win_lo;
    logic [VALUE_W-1:0] win_hi;
    bit stop_req;

    rss_item_if items_ch ();
    rss_result_if events_ch ();

    assign items_ch.valid          = drv_valid;
    assign items_ch.kind           = drv_item.kind;
    assign items_ch.now_ms         = drv_item.now_ms;
    assign items_ch.distance_mm    = drv_item.distance_mm;
    assign items_ch.distance_valid = drv_item.distance_valid;
    assign items_ch.sensor_status  = drv_item.sensor_status;
    assign events_ch.ready         = rx_ready;

    range_session_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_ch),
        .events    (events_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock, 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("** range_session_sequencer_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // event predictor
    // ------------------------------------------------------------------------
    function automatic void seq_reset();
        regs.arm_len          = ARMING_MS_RST;
        regs.cd_len           = COUNTDOWN_MS_RST;
        regs.rec_max          = SESSION_MS_RST;
        regs.hold_len         = END_HOLD_MS_RST;
        regs.hold_tmo         = END_TMO_MS_RST;
        regs.still_mm         = STABLE_MM_RST;
        regs.smoothing_weight = WEIGHT_RST;
        ph       = PH_IDLE;
        ph_t0    = '0;
        avg      = '0;
        avg_on   = 1'b0;
        win_lo   = '1;
        win_hi   = '0;
        stop_req = 1'b0;
    endfunction

    function automatic void add_event(event_e_t code, logic [VALUE_W-1:0] v,
                                      logic [TIME_W-1:0] t);
        res_t r;
        r.event_res = code;
        r.value     = v;
        r.phase     = ph;
        r.time_ms   = t;
        r.last      = 1'b0;
        exp_events.push_back(r);
    endfunction

    task automatic predict_events(input item_t it);
        int unsigned first;
        logic [VALUE_W-1:0] raw;
        logic [WEIGHT_W-1:0] w;
        logic [63:0] acc;
        logic [TIME_W-1:0] elapsed;
        logic [31:0] limit_q8;
        logic [VALUE_W-1:0] span;
        first    = exp_events.size();
        raw      = VALUE_W'(it.distance_mm) << FRAC_BITS;
        limit_q8 = 32'(regs.still_mm) << FRAC_BITS;
        case (it.kind)
            KIND_START:
            begin
                ph       = PH_ARMING;
                ph_t0    = it.now_ms;
                stop_req = 1'b0;
                add_event(EV_START, '0, it.now_ms);
                add_event(EV_ARMING, '0, it.now_ms);
            end
            KIND_STOP:
            begin
                if (ph == PH_RECORDING)
                begin
                    stop_req = 1'b1;
                    add_event(EV_STOP, '0, it.now_ms);
                end
                else
                begin
                    ph = PH_IDLE;
                    add_event(EV_STOP_IDLE, '0, it.now_ms);
                end
            end
            KIND_SAMPLE:
            begin
                if (ph != PH_IDLE && !it.distance_valid)
                begin
                    add_event(EV_ERROR, VALUE_W'(it.sensor_status), it.now_ms);
                end
                else if (ph != PH_IDLE)
                begin
                    // exponential average, first sample loads directly
                    if (!avg_on)
                    begin
                        avg    = raw;
                        avg_on = 1'b1;
                        win_lo = avg;
                        win_hi = avg;
                    end
                    else
                    begin
                        w   = (regs.smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE
                                                                   : regs.smoothing_weight;
                        acc = 64'(w) * 64'(raw) + (64'(WEIGHT_ONE) - 64'(w)) * 64'(avg);
                        avg = acc[WEIGHT_SHIFT +: VALUE_W];
                    end
                    if (avg < win_lo)
                        win_lo = avg;
                    if (avg > win_hi)
                        win_hi = avg;
                    span    = (win_hi >= win_lo) ? (win_hi - win_lo) : '0;
                    elapsed = it.now_ms - ph_t0;

                    // phase sequencing
                    case (ph)
                        PH_ARMING:
                        begin
                            if (elapsed >= 32'(regs.arm_len))
                            begin
                                if (32'(span) <= limit_q8)
                                begin
                                    add_event(EV_BASELINE, avg, it.now_ms);
                                    ph    = PH_COUNTDOWN;
                                    ph_t0 = it.now_ms;
                                    add_event(EV_COUNTDOWN, '0, it.now_ms);
                                end
                                else
                                begin
                                    add_event(EV_HOLD_STILL, span, it.now_ms);
                                    ph_t0 = it.now_ms;
                                end
                                win_lo = avg;
                                win_hi = avg;
                            end
                        end
                        PH_COUNTDOWN:
                        begin
                            if (elapsed >= 32'(regs.cd_len))
                            begin
                                ph    = PH_RECORDING;
                                ph_t0 = it.now_ms;
                                add_event(EV_REC, '0, it.now_ms);
                            end
                        end
                        PH_RECORDING:
                        begin
                            add_event(EV_SAMPLE, raw, it.now_ms);
                            if (stop_req || elapsed >= 32'(regs.rec_max))
                            begin
                                ph       = PH_END_HOLD;
                                ph_t0    = it.now_ms;
                                stop_req = 1'b0;
                                win_lo   = avg;
                                win_hi   = avg;
                                add_event(EV_END_HOLD, '0, it.now_ms);
                            end
                        end
                        PH_END_HOLD:
                        begin
                            if (elapsed >= 32'(regs.hold_len))
                            begin
                                if (32'(span) <= limit_q8)
                                begin
                                    add_event(EV_CLEAN, span, it.now_ms);
                                    ph     = PH_IDLE;
                                    avg_on = 1'b0;
                                end
                                else if (elapsed >= 32'(regs.hold_tmo))
                                begin
                                    add_event(EV_TIMEOUT, span, it.now_ms);
                                    ph     = PH_IDLE;
                                    avg_on = 1'b0;
                                end
                            end
                        end
                        default:
                            ph = PH_IDLE;
                    endcase
                end
            end
            default: ;
        endcase
        // mark the final event of this transaction
        if (exp_events.size() > first)
            exp_events[exp_events.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // driver: inputs change on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        pend_t nxt;
        if (rst_n && (!drv_valid || item_fired))
        begin
            if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct
                && !(pend_q[0].drain_first && exp_events.size() != 0))
            begin
                nxt = pend_q.pop_front();
                drv_item  <= nxt.it;
                drv_valid <= 1'b1;
            end
            else
            begin
                drv_valid <= 1'b0;
            end
        end
        rx_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // monitor: sample both channels on the rising edge
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        item_t got_item;
        res_t want;
        item_fired = rst_n && items_ch.valid && items_ch.ready;
        if (item_fired)
        begin
            got_item.kind           = items_ch.kind;
            got_item.now_ms         = items_ch.now_ms;
            got_item.distance_mm    = items_ch.distance_mm;
            got_item.distance_valid = items_ch.distance_valid;
            got_item.sensor_status  = items_ch.sensor_status;
            predict_events(got_item);
            n_items++;
        end
        if (rst_n && events_ch.valid && events_ch.ready)
        begin
            n_events++;
            ev_count[events_ch.event_res]++;
            if (exp_events.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected event, expected none, actual event %0d value 0x%0h",
                             $time, events_ch.event_res, events_ch.value);
            end
            else
            begin
                want = exp_events.pop_front();
                check_field("event_res", 32'(want.event_res), 32'(events_ch.event_res));
                check_field("value", 32'(want.value), 32'(events_ch.value));
                check_field("phase", 32'(want.phase), 32'(events_ch.phase));
                check_field("time_ms", want.time_ms, events_ch.time_ms);
                check_field("last", 32'(want.last), 32'(events_ch.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [DIST_BITS-1:0] rnd_mm();
        return DIST_BITS'($urandom());
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom());
    endfunction

    function automatic logic [STATUS_W-1:0] rnd_status();
        return STATUS_W'($urandom());
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rnd_cfg(input int unsigned hi);
        return CFG_DATA_W'($urandom_range(hi));
    endfunction

    task automatic push_item(input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t,
                             input logic [DIST_BITS-1:0] mm, input logic ok,
                             input logic [STATUS_W-1:0] status, input bit drain);
        pend_t p;
        p.it.kind           = k;
        p.it.now_ms         = t;
        p.it.distance_mm    = mm;
        p.it.distance_valid = ok;
        p.it.sensor_status  = status;
        p.drain_first       = drain;
        pend_q.push_back(p);
        if (k != KIND_UNUSED)
            queued_items++;
    endtask

    // one session: start, samples around a base distance, maybe a stop
    task automatic queue_session(input int n_samples, input int unsigned max_step);
        logic [TIME_W-1:0] t;
        int base;
        int jit;
        int d;
        int stop_at;
        int i;
        t       = $urandom();
        base    = $urandom_range(4095);
        jit     = ($urandom_range(2) == 0) ? 200 : 3;
        stop_at = ($urandom_range(3) == 0) ? -1 : int'($urandom_range(n_samples - 1));
        // idle noise and broken openings
        case ($urandom_range(5))
            0: push_item(KIND_UNUSED, $urandom(), rnd_mm(), rnd_bit(), rnd_status(), 1'b0);
            1: push_item(KIND_SAMPLE, $urandom(), rnd_mm(), rnd_bit(), rnd_status(), 1'b0);
            2: push_item(KIND_STOP, $urandom(), rnd_mm(), rnd_bit(), rnd_status(), 1'b0);
            default: ;
        endcase
        push_item(KIND_START, t, rnd_mm(), rnd_bit(), rnd_status(),
                  $urandom_range(39) == 0);
        for (i = 0; i < n_samples; i++)
        begin
            t += $urandom_range(max_step);
            if (i == stop_at)
                push_item(KIND_STOP, t, rnd_mm(), rnd_bit(), rnd_status(), 1'b0);
            if ($urandom_range(49) == 0)
                push_item(KIND_START, t, rnd_mm(), rnd_bit(), rnd_status(), 1'b0);
            if ($urandom_range(19) == 0)
                base = $urandom_range(4095);
            d = base + int'($urandom_range(2 * jit)) - jit;
            if (d < 0)
                d = 0;
            if (d > 4095)
                d = 4095;
            if ($urandom_range(15) == 0)
                push_item(KIND_SAMPLE, t, rnd_mm(), 1'b0, rnd_status(), 1'b0);
            else
                push_item(KIND_SAMPLE, t, DIST_BITS'(d), 1'b1, rnd_status(), 1'b0);
        end
    endtask

    task automatic queue_random(input int unsigned target, input int unsigned max_step);
        queued_items = 0;
        while (queued_items < target)
            queue_session($urandom_range(40, 8), max_step);
    endtask

    task automatic write_reg(input cfg_reg_e_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ARMING_MS:       regs.arm_len          = data;
            REG_COUNTDOWN_MS:    regs.cd_len           = data;
            REG_SESSION_MS:      regs.rec_max          = data;
            REG_END_HOLD_MS:     regs.hold_len         = data;
            REG_END_HOLD_TMO_MS: regs.hold_tmo         = data;
            REG_STABLE_RANGE_MM: regs.still_mm         = data[RANGE_W-1:0];
            REG_SMOOTH_WEIGHT:   regs.smoothing_weight = data[WEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] arm,
                                  input logic [CFG_DATA_W-1:0] cd,
                                  input logic [CFG_DATA_W-1:0] sess,
                                  input logic [CFG_DATA_W-1:0] hold,
                                  input logic [CFG_DATA_W-1:0] tmo,
                                  input logic [CFG_DATA_W-1:0] stable,
                                  input logic [CFG_DATA_W-1:0] weight);
        write_reg(REG_ARMING_MS, arm);
        write_reg(REG_COUNTDOWN_MS, cd);
        write_reg(REG_SESSION_MS, sess);
        write_reg(REG_END_HOLD_MS, hold);
        write_reg(REG_END_HOLD_TMO_MS, tmo);
        write_reg(REG_STABLE_RANGE_MM, stable);
        write_reg(REG_SMOOTH_WEIGHT, weight);
        n_settings++;
    endtask

    // wait until every queued transaction is taken and every event returned
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pend_q.size() != 0 || drv_valid || exp_events.size() != 0);
    endtask

    function automatic void set_idling(int mode);
        case (mode)
            1:       begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 53; end
            3:       begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int p;
        int unsigned step;
        int unsigned codes_seen;
        logic [TIME_W-1:0] t0;
        seq_reset();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part under reset settings, no idling
        set_idling(0);
        n_settings = 1;
        t0 = 32'hFFFF_F800;
        @(posedge clk);
        push_item(KIND_UNUSED, t0, 12'hFFF, 1'b1, 8'hFF, 1'b0);
        push_item(KIND_SAMPLE, t0, 12'd100, 1'b1, 8'h00, 1'b0);
        push_item(KIND_SAMPLE, t0, 12'd0, 1'b0, 8'hA5, 1'b0);
        push_item(KIND_STOP, t0, 12'd0, 1'b0, 8'h00, 1'b0);
        push_item(KIND_START, t0, 12'd0, 1'b0, 8'h00, 1'b1);
        push_item(KIND_SAMPLE, t0 + 10, 12'hFFF, 1'b0, 8'hFF, 1'b0);
        push_item(KIND_SAMPLE, t0 + 100, 12'hFFF, 1'b1, 8'h00, 1'b0);
        push_item(KIND_SAMPLE, t0 + 2100, 12'hFFF, 1'b1, 8'h00, 1'b0);
        push_item(KIND_SAMPLE, t0 + 7100, 12'hFFF, 1'b1, 8'h00, 1'b0);
        push_item(KIND_SAMPLE, t0 + 7200, 12'd0, 1'b1, 8'h00, 1'b0);
        push_item(KIND_STOP, t0 + 7300, 12'd0, 1'b1, 8'h00, 1'b0);
        push_item(KIND_SAMPLE, t0 + 7400, 12'd0, 1'b1, 8'h00, 1'b0);
        push_item(KIND_SAMPLE, t0 + 9400, 12'd0, 1'b1, 8'h00, 1'b0);
        push_item(KIND_SAMPLE, t0 + 12400, 12'd0, 1'b1, 8'h00, 1'b0);
        push_item(KIND_START, 32'd0, 12'd0, 1'b1, 8'h00, 1'b0);
        push_item(KIND_SAMPLE, 32'd0, 12'd0, 1'b1, 8'h00, 1'b0);
        push_item(KIND_SAMPLE, 32'd2000, 12'hFFF, 1'b1, 8'h00, 1'b0);
        push_item(KIND_START, 32'd2100, 12'd0, 1'b1, 8'h00, 1'b0);
        push_item(KIND_STOP, 32'd2200, 12'd0, 1'b1, 8'h00, 1'b0);
        push_item(KIND_START, 32'd3000, 12'd0, 1'b1, 8'h00, 1'b0);
        push_item(KIND_SAMPLE, 32'd3000, 12'd2048, 1'b1, 8'h00, 1'b0);
        push_item(KIND_SAMPLE, 32'd5000, 12'd2050, 1'b1, 8'h00, 1'b0);
        queue_random(230, 700);

        // random phases, each under its own register setting
        for (p = 1; p < 7; p++)
        begin
            wait_drained();
            repeat (8) @(negedge clk);
            case (p)
                1:
                begin
                    apply_settings(rnd_cfg(60), rnd_cfg(60), rnd_cfg(60),
                                   rnd_cfg(60), rnd_cfg(60), rnd_cfg(40),
                                   CFG_DATA_W'($urandom_range(256, 1)));
                    step = 30;
                end
                2:
                begin
                    apply_settings('0, '0, '0, '0, '0, '0, '0);
                    step = 10;
                end
                3:
                begin
                    apply_settings('1, '1, '1, '1, '1, '1, '1);
                    step = 32'd1 << 21;
                end
                4:
                begin
                    apply_settings(rnd_cfg(3000), rnd_cfg(3000), rnd_cfg(3000),
                                   rnd_cfg(3000), rnd_cfg(3000), 20'd25, 20'd256);
                    step = 1500;
                end
                5:
                begin
                    apply_settings(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                                   CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                                   CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                                   CFG_DATA_W'($urandom()));
                    step = 32'd1 << 19;
                end
                default:
                begin
                    apply_settings(rnd_cfg(200), rnd_cfg(200), rnd_cfg(200),
                                   rnd_cfg(200), rnd_cfg(200),
                                   CFG_DATA_W'($urandom_range(10, 1)),
                                   CFG_DATA_W'($urandom_range(256, 1)));
                    step = 100;
                end
            endcase
            set_idling(p % 4);
            @(posedge clk);
            queue_random(200, step);
        end

        // drain and let any late event show up
        wait_drained();
        repeat (20) @(posedge clk);
        codes_seen = 0;
        for (p = 0; p <= int'(EV_TIMEOUT); p++)
            if (ev_count[p] != 0)
                codes_seen++;
        $display("covered %0d transactions in and %0d events out over %0d register settings",
                 n_items, n_events, n_settings);
        $display("%0d of %0d event codes seen, %0d mismatches",
                 codes_seen, int'(EV_TIMEOUT) + 1, err_count);
        if (err_count == 0)
            $display("** range_session_sequencer_core: PASSED **");
        else
            $display("** range_session_sequencer_core: FAILED **");
        $finish;
    end

endmodule
